// File: rtl/thermal_head_heat_time_unit_macros.svh
// Assertion macros used by the heat time unit control RTL.
`ifndef THERMAL_HEAD_HEAT_TIME_UNIT_MACROS_SVH
`define THERMAL_HEAD_HEAT_TIME_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks that a property holds at every clock edge outside reset.
`define THHT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("thht assertion failed");
// Checks that a condition never becomes true outside reset.
`define THHT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("thht forbidden condition seen");
`else
`define THHT_ASSERT(lbl, clk, rst_n, prop)
`define THHT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/thht_pkg.sv
// Types, tables and constants of the heat time unit.
package thht_pkg;

    localparam int NUM_STAGES = 5;
    localparam int ST_LOOK    = 0;
    localparam int ST_MUL     = 1;
    localparam int ST_DIV     = 2;
    localparam int ST_DMUL    = 3;
    localparam int ST_OUT     = 4;

    localparam int MV_W    = 14;
    localparam int TEMP_W  = 8;
    localparam int BASE_W  = 10;
    localparam int FACT_W  = 8;
    localparam int PROD1_W = 18;
    localparam int TM_W    = 12;
    localparam int DARK_W  = 8;
    localparam int PROD2_W = 20;
    localparam int OUT_W   = 13;

    localparam logic signed [TEMP_W:0] T_LOW  = 9'sd25;
    localparam logic signed [TEMP_W:0] T_HIGH = 9'sd70;
    localparam logic [FACT_W-1:0]      HOT_PCT  = 8'd50;
    localparam logic [DARK_W-1:0]      GRAY_MIN = 8'd50;
    localparam logic [DARK_W-1:0]      GRAY_MAX = 8'd250;
    localparam logic [OUT_W-1:0]       OUT_MAX  = 13'd8191;

    // Reciprocal constants: x / d == (x * m) >> s for every x of the given width.
    localparam int               RECIP_A_SHIFT = 25;
    localparam int               RECIP_A_W     = 20;
    localparam logic [19:0]      RECIP_A_100   = 20'd335545;
    localparam logic [19:0]      RECIP_A_62    = 20'd541201;
    localparam int               RECIP_B_SHIFT = 27;
    localparam int               RECIP_B_W     = 21;
    localparam logic [20:0]      RECIP_B_100   = 21'd1342178;

    typedef logic [NUM_STAGES-1:0] stage_vec_t;

    typedef struct packed {
        stage_vec_t load;
        stage_vec_t valid;
    } stage_ctl_t;

    localparam logic [MV_W-1:0] VOLT_THRESH [16] = '{
        14'd9400, 14'd9200, 14'd9000, 14'd8800, 14'd8600, 14'd8400, 14'd8200, 14'd8000,
        14'd7800, 14'd7600, 14'd7400, 14'd7200, 14'd7000, 14'd6800, 14'd6600, 14'd6400
    };

    localparam logic [BASE_W-1:0] VOLT_TIME [16] = '{
        10'd400, 10'd450, 10'd480, 10'd500, 10'd520, 10'd540, 10'd580, 10'd600,
        10'd640, 10'd680, 10'd715, 10'd760, 10'd800, 10'd850, 10'd900, 10'd960
    };

    // First entry whose threshold the voltage exceeds; the last entry otherwise.
    function automatic logic [BASE_W-1:0] base_time(input logic [MV_W-1:0] mv);
        logic [BASE_W-1:0] res;
        res = VOLT_TIME[15];
        for (int k = 15; k >= 0; k--)
        begin
            if (mv > VOLT_THRESH[k])
            begin
                res = VOLT_TIME[k];
            end
        end
        return res;
    endfunction

    // Percentage for 25 C upward, indexed by degrees above 25 C.
    function automatic logic [FACT_W-1:0] temp_pct(input logic [5:0] idx);
        logic [FACT_W-1:0] pct;
        case (idx)
            6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: pct = 8'd100;
            6'd6:                               pct = 8'd95;
            6'd7:                               pct = 8'd94;
            6'd8:                               pct = 8'd93;
            6'd9:                               pct = 8'd92;
            6'd10:                              pct = 8'd91;
            6'd11, 6'd12:                       pct = 8'd80;
            6'd13, 6'd14, 6'd15:                pct = 8'd76;
            6'd16, 6'd17:                       pct = 8'd73;
            6'd18, 6'd19, 6'd20:                pct = 8'd70;
            6'd21, 6'd22, 6'd23, 6'd24, 6'd25:  pct = 8'd67;
            6'd26, 6'd27:                       pct = 8'd64;
            6'd28, 6'd29, 6'd30:                pct = 8'd63;
            6'd31, 6'd32:                       pct = 8'd61;
            6'd33, 6'd34, 6'd35:                pct = 8'd59;
            6'd36, 6'd37:                       pct = 8'd57;
            6'd38, 6'd39, 6'd40:                pct = 8'd55;
            default:                            pct = 8'd50;
        endcase
        return pct;
    endfunction

endpackage

// File: rtl/thht_ctrl.sv
// Valid bits and per-stage load enables of the heat time pipeline.
`include "thermal_head_heat_time_unit_macros.svh"
module thht_ctrl
    import thht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_ready,
    output logic       in_ready,
    output stage_ctl_t ctl
);

    stage_vec_t valid_reg;
    stage_vec_t valid_next;
    stage_vec_t load;

    // A stage takes new data when it is empty or its content moves on.
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = (i == 0) ? in_valid : valid_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = load[0];
    assign ctl.load  = load;
    assign ctl.valid = valid_reg;

    logic in_fire;
    logic out_fire;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = valid_reg[NUM_STAGES-1] && out_ready;

    `THHT_ASSERT(a_in_enters, clk, rst_n, in_fire |=> valid_reg[0])
    `THHT_ASSERT(a_beat_count, clk, rst_n, 1'b1 |=> ($countones(valid_reg) == $countones($past(valid_reg)) + int'($past(in_fire)) - int'($past(out_fire))))
    `THHT_NEVER(a_stall_only_full, clk, rst_n, !in_ready && !((&valid_reg) && !out_ready))

endmodule

// File: rtl/thht_temp.sv
// Voltage lookup and temperature correction stages of the heat time pipeline.
module thht_temp
    import thht_pkg::*;
(
    input  logic              clk,
    input  stage_ctl_t        ctl,
    input  logic [MV_W-1:0]   supply_mv,
    input  logic [TEMP_W-1:0] head_temp_c,
    output logic [TM_W-1:0]   tm
);

    logic signed [TEMP_W:0] temp_ext;
    logic signed [TEMP_W:0] diff_cold;
    logic signed [TEMP_W:0] diff_warm;
    logic                   is_cold;
    logic [FACT_W-1:0]      factor;

    logic [BASE_W-1:0]  base1_reg;
    logic [FACT_W-1:0]  factor1_reg;
    logic               cold1_reg;
    logic [PROD1_W-1:0] prod2_reg;
    logic [BASE_W-1:0]  base2_reg;
    logic               cold2_reg;
    logic [TM_W-1:0]    tm3_reg;

    assign temp_ext  = {head_temp_c[TEMP_W-1], head_temp_c};
    assign diff_cold = T_LOW - temp_ext;
    assign diff_warm = temp_ext - T_LOW;
    assign is_cold   = temp_ext < T_LOW;

    // Cold items carry the degree count below 25 C; the others a percentage.
    always_comb
    begin
        if (is_cold)
        begin
            factor = diff_cold[FACT_W-1:0];
        end
        else if (temp_ext > T_HIGH)
        begin
            factor = HOT_PCT;
        end
        else
        begin
            factor = temp_pct(diff_warm[5:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[ST_LOOK])
        begin
            base1_reg   <= base_time(supply_mv);
            factor1_reg <= factor;
            cold1_reg   <= is_cold;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[ST_MUL])
        begin
            prod2_reg <= PROD1_W'(base1_reg * factor1_reg);
            base2_reg <= base1_reg;
            cold2_reg <= cold1_reg;
        end
    end

    logic [RECIP_A_W-1:0]         magic;
    logic [PROD1_W+RECIP_A_W-1:0] recip_full;
    logic [TM_W-1:0]              quot;
    logic [TM_W-1:0]              tm_next;

    // Divide by 62 for cold items, by 100 otherwise.
    assign magic      = cold2_reg ? RECIP_A_62 : RECIP_A_100;
    assign recip_full = prod2_reg * magic;
    assign quot       = recip_full[RECIP_A_SHIFT+TM_W-1:RECIP_A_SHIFT];
    assign tm_next    = cold2_reg ? (TM_W'(base2_reg) + quot) : quot;

    always_ff @(posedge clk)
    begin
        if (ctl.load[ST_DIV])
        begin
            tm3_reg <= tm_next;
        end
    end

    assign tm = tm3_reg;

endmodule

// File: rtl/thht_dark.sv
// Darkness scaling and saturation stages of the heat time pipeline.
module thht_dark
    import thht_pkg::*;
(
    input  logic              clk,
    input  stage_ctl_t        ctl,
    input  logic [TM_W-1:0]   tm,
    input  logic [DARK_W-1:0] darkness,
    output logic [OUT_W-1:0]  heat_time
);

    logic [PROD2_W-1:0] prod4_reg;
    logic [TM_W-1:0]    tm4_reg;
    logic               scale4_reg;
    logic [OUT_W-1:0]   out5_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[ST_DMUL])
        begin
            prod4_reg  <= PROD2_W'(tm * darkness);
            tm4_reg    <= tm;
            scale4_reg <= (darkness >= GRAY_MIN) && (darkness <= GRAY_MAX);
        end
    end

    localparam int QUOT_W = PROD2_W + RECIP_B_W - RECIP_B_SHIFT;

    logic [PROD2_W+RECIP_B_W-1:0] recip_full;
    logic [QUOT_W-1:0]            scaled;
    logic [QUOT_W-1:0]            result;

    assign recip_full = prod4_reg * RECIP_B_100;
    assign scaled     = recip_full[PROD2_W+RECIP_B_W-1:RECIP_B_SHIFT];
    assign result     = scale4_reg ? scaled : QUOT_W'(tm4_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load[ST_OUT])
        begin
            if (result > QUOT_W'(OUT_MAX))
            begin
                out5_reg <= OUT_MAX;
            end
            else
            begin
                out5_reg <= result[OUT_W-1:0];
            end
        end
    end

    assign heat_time = out5_reg;

endmodule

// File: rtl/thermal_head_heat_time_unit.sv
// Top level of the thermal head strobe heat time unit.
//
//  channel   direction  handshake               payload
//  input     in         in_valid / in_ready     supply_mv, head_temp_c
//  output    out        out_valid / out_ready   heat_time_us
//  config    in         cfg_we                  cfg_data (darkness percent)
//
// Five register stages: voltage lookup, temperature multiply, reciprocal divide,
// darkness multiply, reciprocal divide with saturation into the output register.
// A new beat can enter every cycle unless an output stall has filled all stages.
// Reset clears the valid bits and sets the darkness register to zero.
// An output stall holds full stages with no empty stage after them; others move.
module thermal_head_heat_time_unit
    import thht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [DARK_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MV_W-1:0]   supply_mv,
    input  logic [TEMP_W-1:0] head_temp_c,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [OUT_W-1:0]  heat_time_us
);

    logic [DARK_W-1:0] darkness_reg;
    stage_ctl_t        ctl;
    logic [TM_W-1:0]   tm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            darkness_reg <= '0;
        end
        else if (cfg_we)
        begin
            darkness_reg <= cfg_data;
        end
    end

    thht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .ctl       (ctl)
    );

    thht_temp u_temp (
        .clk         (clk),
        .ctl         (ctl),
        .supply_mv   (supply_mv),
        .head_temp_c (head_temp_c),
        .tm          (tm)
    );

    thht_dark u_dark (
        .clk       (clk),
        .ctl       (ctl),
        .tm        (tm),
        .darkness  (darkness_reg),
        .heat_time (heat_time_us)
    );

    assign out_valid = ctl.valid[ST_OUT];

endmodule
